[rtl/occs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package occs_pkg;

   localparam int unsigned SumWidth  = 16;
   localparam int unsigned ByteWidth = 8;

   localparam logic [SumWidth-1:0] ONES_ZERO = 16'hffff;

   localparam logic MODE_RAW = 1'b0;
   localparam logic MODE_ADD = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [SumWidth-1:0]  start_value;
      logic                 start_odd;
      logic [ByteWidth-1:0] data_byte;
      logic                 byte_valid;
      logic                 first;
      logic                 last;
   } occs_item_type;

endpackage

`default_nettype wire

[rtl/occs_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface occs_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [occs_pkg::SumWidth-1:0]   start_value;
   logic                            start_odd;
   logic [occs_pkg::ByteWidth-1:0]  data_byte;
   logic                            byte_valid;
   logic                            first;
   logic                            last;

   modport source (
      output valid, mode, start_value, start_odd, data_byte, byte_valid, first, last,
      input  ready
   );
   modport sink (
      input  valid, mode, start_value, start_odd, data_byte, byte_valid, first, last,
      output ready
   );
endinterface

interface occs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [occs_pkg::SumWidth-1:0] checksum;

   modport source (output valid, checksum, input ready);
   modport sink   (input valid, checksum, output ready);
endinterface

`default_nettype wire

[rtl/ones_complement_checksum_stream.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming 16-bit ones' complement checksum over runs of bytes.
// req_if carries one item per transfer: an optional byte (byte_valid) with
// first/last run markers; first loads mode, start_value and start_odd.
// rsp_if carries one checksum per run, produced by the transfer with last set,
// folded, in network order, zero reported as 0xffff (add mode complements).
// The checksum appears on rsp_if the cycle after the last transfer.
// Throughput: one item per cycle while req_if is ready; the running sum update is
// a single 16-bit end-around add per byte between the running-sum register and
// the output register.
// The output register decouples the sides: req_if stays ready while no
// checksum is pending or the pending one is taken in the same cycle; a stalled
// rsp_if holds its checksum and blocks new items only then.
// Reset clears the running sum, byte parity and mode to zero, even and raw, and
// drops any pending checksum.

module ones_complement_checksum_stream (
   input  wire logic  clock,
   input  wire logic  reset,
   occs_req_if.sink   req_if,
   occs_rsp_if.source rsp_if
);

   occs_pkg::occs_item_type       item;
   logic                          req_accept;
   logic [occs_pkg::SumWidth-1:0] result;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [occs_pkg::SumWidth-1:0] rsp_checksum_ff;

   assign item = '{
      mode:        req_if.mode,
      start_value: req_if.start_value,
      start_odd:   req_if.start_odd,
      data_byte:   req_if.data_byte,
      byte_valid:  req_if.byte_valid,
      first:       req_if.first,
      last:        req_if.last
   };

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   occs_sum u_sum (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .item   (item),
      .result (result)
   );

   always_comb begin
      if (req_accept && req_if.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_if.last) begin
         rsp_checksum_ff <= result;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.checksum = rsp_checksum_ff;

   // a new checksum only follows a last transfer
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(req_accept && req_if.last))
      else $error("checksum without last transfer");

   // a pending checksum that is not taken blocks the input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !req_if.ready)
      else $error("input ready while checksum stalled");

   // zero is always reported as all ones
   a_no_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.checksum != '0))
      else $error("zero checksum reported");

endmodule

`default_nettype wire

[rtl/occs_sum.sv]
`timescale 1ns / 1ps
`default_nettype none

module occs_sum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire occs_pkg::occs_item_type       item,
   output logic [occs_pkg::SumWidth-1:0]      result
);

   logic [occs_pkg::SumWidth-1:0] sum_ff, sum_in;
   logic                          parity_ff, parity_in;
   logic                          add_mode_ff, add_mode_in;

   logic [occs_pkg::SumWidth-1:0] base_sum;
   logic                          base_parity;
   logic [occs_pkg::SumWidth-1:0] word;
   logic [occs_pkg::SumWidth:0]   total;
   logic [occs_pkg::SumWidth-1:0] folded;
   logic [occs_pkg::SumWidth-1:0] mapped;

   // start load on the first transfer of a run
   always_comb begin
      if (item.first) begin
         base_sum    = (item.mode == occs_pkg::MODE_ADD) ? ~item.start_value
                                                         : item.start_value;
         base_parity = item.start_odd;
         add_mode_in = item.mode;
      end else begin
         base_sum    = sum_ff;
         base_parity = parity_ff;
         add_mode_in = add_mode_ff;
      end
   end

   // big-endian pairing, end-around carry
   always_comb begin
      word   = base_parity ? {{occs_pkg::ByteWidth{1'b0}}, item.data_byte}
                           : {item.data_byte, {occs_pkg::ByteWidth{1'b0}}};
      total  = {1'b0, base_sum} + {1'b0, word};
      folded = total[occs_pkg::SumWidth-1:0]
             + {{(occs_pkg::SumWidth-1){1'b0}}, total[occs_pkg::SumWidth]};
      sum_in    = item.byte_valid ? folded : base_sum;
      parity_in = base_parity ^ item.byte_valid;
   end

   always_comb begin
      mapped = (sum_in == '0) ? occs_pkg::ONES_ZERO : sum_in;
      if (add_mode_in == occs_pkg::MODE_ADD && mapped != occs_pkg::ONES_ZERO) begin
         result = ~mapped;
      end else begin
         result = mapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         parity_ff   <= 1'b0;
         add_mode_ff <= occs_pkg::MODE_RAW;
      end else if (accept) begin
         sum_ff      <= sum_in;
         parity_ff   <= parity_in;
         add_mode_ff <= add_mode_in;
      end
   end

endmodule

`default_nettype wire
